@@ hw/rtl/rlhs_pkg.sv @@
// Shared constants, types and the luma function for the RGB565 luma and half-scale block.
package rlhs_pkg;

    localparam int MAX_WIDTH     = 512;
    localparam int HEIGHT_LIMIT  = 512;
    localparam int PAIR_DEPTH    = MAX_WIDTH / 2;
    localparam int COUNT_W       = $clog2(MAX_WIDTH);
    localparam int PAIR_IDX_W    = $clog2(PAIR_DEPTH);
    localparam int CFG_W         = 10;
    localparam int PIXEL_W       = 16;
    localparam int LUMA_W        = 8;
    localparam int PAIR_W        = LUMA_W + 1;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = CFG_W'(400);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(240);
    localparam logic [CFG_W-1:0] DIM_MIN            = CFG_W'(2);
    localparam logic [CFG_W-1:0] WIDTH_MAX          = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MAX         = CFG_W'(HEIGHT_LIMIT);

    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIXEL_W-1:0]    pixel_word;
        logic                  col_odd;
        logic                  row_odd;
        logic [PAIR_IDX_W-1:0] pair_idx;
        logic                  frame_end;
    } item_t;

    function automatic logic [LUMA_W-1:0] luma_of(input logic [PIXEL_W-1:0] raw);
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        logic [15:0] sum;
        r8  = {raw[7:3], 3'b000};
        g8  = {raw[2:0], raw[15:13], 2'b00};
        b8  = {raw[12:8], 3'b000};
        sum = 16'(r8) * 16'd77 + 16'(g8) * 16'd150 + 16'(b8) * 16'd29;
        return sum[15:8];
    endfunction

endpackage

@@ hw/rtl/rlhs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rlhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rlhs_front.sv @@
// Front end: configuration registers, pixel acceptance and column/row position tracking.
module rlhs_front import rlhs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    logic [CFG_W-1:0]   line_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [CFG_W-1:0]   width_eff;
    logic [CFG_W-1:0]   height_eff;
    logic [CFG_W-1:0]   col_plus;
    logic [CFG_W-1:0]   row_plus;
    logic               line_end;
    logic               last_row;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_LINE_WIDTH) begin
                line_width_reg <= pwdata[CFG_W-1:0];
            end else begin
                frame_height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_LINE_WIDTH:   prdata[CFG_W-1:0] = line_width_reg;
            REG_FRAME_HEIGHT: prdata[CFG_W-1:0] = frame_height_reg;
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (line_width_reg < DIM_MIN) begin
            width_eff = DIM_MIN;
        end else if (line_width_reg > WIDTH_MAX) begin
            width_eff = WIDTH_MAX;
        end else begin
            width_eff = line_width_reg;
        end
        if (frame_height_reg < DIM_MIN) begin
            height_eff = DIM_MIN;
        end else if (frame_height_reg > HEIGHT_MAX) begin
            height_eff = HEIGHT_MAX;
        end else begin
            height_eff = frame_height_reg;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign col_plus = CFG_W'(col_reg) + CFG_W'(1);
    assign row_plus = CFG_W'(row_reg) + CFG_W'(1);
    assign line_end = col_plus >= width_eff;
    assign last_row = row_plus >= height_eff;

    always_comb begin
        q_item.pixel_word = s_tdata;
        q_item.col_odd    = col_reg[0];
        q_item.row_odd    = row_reg[0];
        q_item.pair_idx   = col_reg[COUNT_W-1:1];
        q_item.frame_end  = line_end && last_row;
        col_next = col_reg;
        row_next = row_reg;
        if (q_push) begin
            if (line_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[COUNT_W-1:0];
            end else begin
                col_next = col_plus[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ hw/rtl/rlhs_queue.sv @@
// Short FIFO that decouples the front end from the back end.
module rlhs_queue import rlhs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/rlhs_back.sv @@
// Back end: luma computation, pair-sum line store and 2x2 block averaging.
module rlhs_back import rlhs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    item_t             s1_item_reg;
    logic [LUMA_W-1:0] s1_y_reg;
    logic              s1_valid_reg;
    logic [LUMA_W-1:0] left_reg;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg;
    logic              out_user_reg;
    logic              out_last_reg;
    logic              out_ready;
    logic              s1_ready;
    logic              advance;
    logic [PAIR_W-1:0] pair;
    logic [PAIR_W-1:0] line_rdata;
    logic [PAIR_W:0]   block_sum;
    logic              half_valid;
    logic              line_we;

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_pop     = q_valid && s1_ready;
    assign advance   = s1_valid_reg && out_ready;

    rlhs_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (PAIR_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (s1_item_reg.pair_idx),
        .wdata (pair),
        .re    (q_pop),
        .raddr (q_item.pair_idx),
        .rdata (line_rdata)
    );

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_item_reg <= q_item;
            s1_y_reg    <= luma_of(q_item.pixel_word);
        end
    end

    assign pair       = PAIR_W'(left_reg) + PAIR_W'(s1_y_reg);
    assign block_sum  = (PAIR_W + 1)'(line_rdata) + (PAIR_W + 1)'(pair);
    assign half_valid = s1_item_reg.col_odd && s1_item_reg.row_odd;
    assign line_we    = advance && s1_item_reg.col_odd && !s1_item_reg.row_odd;

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg[LUMA_W-1:0] <= s1_y_reg;
            out_data_reg[15:LUMA_W]  <= half_valid ? block_sum[PAIR_W:2] : '0;
            out_user_reg             <= half_valid;
            out_last_reg             <= s1_item_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && !s1_item_reg.col_odd) begin
                left_reg <= s1_y_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/rgb565_luma_with_half_scale.sv @@
// Top level of the RGB565 to luma converter with 2x2 box downsample.
// A word accepted on the input passes through the queue, the luma stage register and the output register.
// Throughput: one word per cycle while the output is not stalled, set by the luma stage and one line-store access.
// The four-entry queue keeps accepting words while the output stalls, until it is full.
// Reset clears the position counters, the left luma, the queue and the output valid,
// and loads line_width 400 and frame_height 240; the line store is not cleared.
module rgb565_luma_with_half_scale import rlhs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] luma, [15:8] half_luma
    output logic        m_tuser,   // [0] half_valid
    output logic        m_tlast
);

    item_t push_item;
    item_t head_item;
    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;

    rlhs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rlhs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    rlhs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/rlhs_checker.sv @@
// Port-level assertions for the luma block and the bind that attaches them.
module rlhs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled output word changed.");

    a_half_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[15:8] == 8'd0)
        else $error("Half luma is nonzero without a completed block.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && !paddr[2]
        |=> paddr[2] || prdata[9:0] == $past(pwdata[9:0]))
        else $error("Line width readback does not match the written value.");

endmodule

bind rgb565_luma_with_half_scale rlhs_checker u_rlhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for rgb565_luma_with_half_scale: random pixel streams against a predictor.
module tb_top import rlhs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;

    class luma_scoreboard;
        typedef struct {
            logic [LUMA_W-1:0] luma;
            logic              half_valid;
            logic [LUMA_W-1:0] half_luma;
            logic              frame_end;
        } pixel_result_t;

        logic [CFG_W-1:0]  width_reg;
        logic [CFG_W-1:0]  height_reg;
        logic [PAIR_W-1:0] pair_line [PAIR_DEPTH];
        logic [LUMA_W-1:0] left;
        int unsigned       col;
        int unsigned       row;
        pixel_result_t     expected_q [$];
        int                errors;

        function new();
            width_reg  = LINE_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            foreach (pair_line[i]) pair_line[i] = '0;
            left   = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_LINE_WIDTH) width_reg = val;
            else height_reg = val;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 2) return 2;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit on_odd_row();
            return row % 2 == 1;
        endfunction

        function int unsigned row_remaining();
            int unsigned w;
            w = clamp_dim(width_reg, MAX_WIDTH);
            return (col + 1 >= w) ? 1 : w - col;
        endfunction

        function logic [LUMA_W-1:0] pixel_luma(logic [PIXEL_W-1:0] raw);
            logic [15:0] px;
            int unsigned red, green, blue;
            px    = {raw[7:0], raw[15:8]};
            red   = int'(px[15:11]) * 8;
            green = int'(px[10:5]) * 4;
            blue  = int'(px[4:0]) * 8;
            return LUMA_W'((77 * red + 150 * green + 29 * blue) >> 8);
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] raw);
            int unsigned       w, h, idx;
            logic [LUMA_W-1:0] y;
            logic [PAIR_W-1:0] pair;
            pixel_result_t     res;
            bit                line_end, last_row;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, HEIGHT_LIMIT);
            y = pixel_luma(raw);
            res.luma       = y;
            res.half_valid = 1'b0;
            res.half_luma  = '0;
            if (col % 2 == 0) begin
                left = y;
            end else begin
                pair = PAIR_W'(left) + PAIR_W'(y);
                idx  = (col >> 1) % PAIR_DEPTH;
                if (row % 2 == 0) begin
                    pair_line[idx] = pair;
                end else begin
                    res.half_luma  = LUMA_W'((10'(pair_line[idx]) + 10'(pair)) >> 2);
                    res.half_valid = 1'b1;
                end
            end
            line_end      = col + 1 >= w;
            last_row      = row + 1 >= h;
            res.frame_end = line_end && last_row;
            if (line_end) begin
                col = 0;
                row = last_row ? 0 : (row + 1) % (1 << COUNT_W);
            end else begin
                col = (col + 1) % (1 << COUNT_W);
            end
            expected_q.push_back(res);
        endfunction

        task check_result(logic [LUMA_W-1:0] luma, logic half_valid,
                          logic [LUMA_W-1:0] half_luma, logic frame_end);
            pixel_result_t exp_res;
            if (expected_q.size() == 0) begin
                report("output word with no pending pixel");
            end else begin
                exp_res = expected_q.pop_front();
                if (luma !== exp_res.luma)
                    report($sformatf("luma %0d, expected %0d", luma, exp_res.luma));
                if (half_valid !== exp_res.half_valid)
                    report($sformatf("half_valid %0b, expected %0b",
                                     half_valid, exp_res.half_valid));
                if (half_luma !== exp_res.half_luma)
                    report($sformatf("half_luma %0d, expected %0d",
                                     half_luma, exp_res.half_luma));
                if (frame_end !== exp_res.frame_end)
                    report($sformatf("frame_end %0b, expected %0b",
                                     frame_end, exp_res.frame_end));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    luma_scoreboard sb = new();
    bit             steady_flow = 1'b0;
    bit             hold_request = 1'b0;

    rgb565_luma_with_half_scale i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata[7:0], m_tuser, m_tdata[15:8], m_tlast);
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady_flow || $urandom_range(0, 99) >= 10;
            end
        end
    end

    task automatic send_pixel(input logic [15:0] pixel);
        if (!steady_flow && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic pause_and_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic idx, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        logic [31:0] rd;
        apb_access(1'b1, idx, 32'(val), rd);
        sb.set_reg(idx, val);
        apb_access(1'b0, idx, '0, rd);
        if (rd !== 32'(val))
            sb.report($sformatf("register %0d reads %0h, expected %0h", idx, rd, val));
    endtask

    task automatic set_dims(input bit do_w, input int unsigned w,
                            input bit do_h, input int unsigned h);
        if (do_w) write_reg(REG_LINE_WIDTH, CFG_W'(w));
        if (do_h) write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 1023;
            3: return 512;
            4: return 3;
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    initial begin
        logic [15:0] first_px [4];
        logic [15:0] odd_px [9];
        int          random_sent;
        int          phase;
        int          burst;
        int unsigned n;
        bit          do_w, do_h;
        int unsigned w, h;
        first_px = '{16'hFFFF, 16'h0000, 16'h00F8, 16'hE007};
        odd_px   = '{16'h0000, 16'hFFFF, 16'h1F00, 16'h00F8, 16'hE007,
                     16'hFFFF, 16'h0000, 16'h1F00, 16'hFFFF};
        random_sent = 0;
        phase       = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset dimensions first, then a shrink that ends the row early, then 2x2 and 3x3 frames.
        foreach (first_px[i]) send_pixel(first_px[i]);
        pause_and_drain();
        set_dims(1'b1, 2, 1'b1, 2);
        send_pixel(16'h1F00);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        repeat (4) send_pixel(16'hFFFF);
        pause_and_drain();
        set_dims(1'b1, 3, 1'b1, 3);
        foreach (odd_px[i]) send_pixel(odd_px[i]);
        pause_and_drain();

        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin do_w = 1; w = 0;    do_h = 1; h = 1023; end
                1: begin do_w = 1; w = 1023; do_h = 1; h = 0;    end
                2: begin do_w = 1; w = 512;  do_h = 1; h = 512;  end
                3: begin do_w = 1; w = 1;    do_h = 1; h = 1;    end
                default: begin
                    do_w = $urandom_range(0, 1);
                    do_h = $urandom_range(0, 1);
                    w    = pick_dim();
                    h    = pick_dim();
                end
            endcase
            // The line store is only consistent if the width changes while an even row runs.
            if (do_w && sb.on_odd_row()) begin
                n = sb.row_remaining();
                repeat (n) send_pixel(16'($urandom_range(0, 16'hFFFF)));
                random_sent += n;
                pause_and_drain();
            end
            set_dims(do_w, w, do_h, h);
            steady_flow = (phase == 4 || phase == 9);
            if (phase == 6 || phase == 11) begin
                hold_request = 1'b1;
                burst        = 60;
            end else begin
                burst = $urandom_range(20, 100);
            end
            repeat (burst) send_pixel(16'($urandom_range(0, 16'hFFFF)));
            random_sent += burst;
            pause_and_drain();
            steady_flow = 1'b0;
            phase++;
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
